### rtl/fnv_pkg.sv
// fnv_pkg: types, constants and the log2 table generator for the
// frequency to note/velocity converter. No dependencies.
`default_nettype none

package fnv_pkg;

  // Field widths
  localparam int unsigned FREQ_W  = 24;
  localparam int unsigned MAG_W   = 16;
  localparam int unsigned NOTE_W  = 9;
  localparam int unsigned INTON_W = 9;
  localparam int unsigned VEL_W   = 7;
  localparam int unsigned NUM7_W  = 7;

  // Log2 result: 5-bit exponent over 16 fraction bits
  localparam int unsigned EXP_W   = 5;
  localparam int unsigned FRAC_W  = 23;
  localparam int unsigned LOG_W   = 21;
  localparam int unsigned TAB_W   = 17;

  localparam int unsigned LOG_TAB_ENTRIES_DEF = 64;

  // APB register map
  localparam int unsigned CFG_AW  = 5;
  localparam int unsigned CFG_DW  = 32;
  localparam int unsigned REG_IW  = CFG_AW - 2;

  localparam logic [REG_IW-1:0] REG_REF_FREQ = 3'd0;
  localparam logic [REG_IW-1:0] REG_REF_NOTE = 3'd1;
  localparam logic [REG_IW-1:0] REG_LOW_NOTE = 3'd2;
  localparam logic [REG_IW-1:0] REG_HIGH_NOTE = 3'd3;
  localparam logic [REG_IW-1:0] REG_VEL_FLOOR = 3'd4;
  localparam logic [REG_IW-1:0] REG_VEL_CEIL = 3'd5;

  localparam logic [FREQ_W-1:0] REF_FREQ_RST = 24'd112640;
  localparam logic [NUM7_W-1:0] REF_NOTE_RST = 7'd69;
  localparam logic [NUM7_W-1:0] LOW_NOTE_RST = 7'd21;
  localparam logic [NUM7_W-1:0] HIGH_NOTE_RST = 7'd108;
  localparam logic [NUM7_W-1:0] VEL_FLOOR_RST = 7'd0;
  localparam logic [NUM7_W-1:0] VEL_CEIL_RST = 7'd127;

  // Velocity mapping: magnitude clamp in Q8.8 dB, span and reciprocal of 399
  localparam logic signed [MAG_W-1:0] MAG_MIN_Q8 = -16'sd25600;
  localparam logic signed [MAG_W-1:0] MAG_MAX_Q8 = -16'sd64;
  localparam int unsigned VEL_K_W    = 15;
  localparam int unsigned VEL_NUM_W  = 22;
  localparam logic [VEL_K_W-1:0] VEL_SPAN = 15'd25536;
  localparam int unsigned VEL_PRE_SH = 6;          // 25536 = 64 * 399
  localparam logic [31:0] VEL_RECIP  = 32'd84097;  // ceil(2^25 / 399)
  localparam int unsigned VEL_RECIP_SH = 25;

  localparam logic signed [NOTE_W-1:0] NOTE_MIN = -9'sd256;
  localparam logic signed [NOTE_W-1:0] NOTE_MAX = 9'sd255;

  typedef struct packed {
    logic [NUM7_W-1:0] ref_note;
    logic [NUM7_W-1:0] lowest_note;
    logic [NUM7_W-1:0] highest_note;
    logic [NUM7_W-1:0] vel_floor;
    logic [NUM7_W-1:0] vel_ceil;
    logic [LOG_W-1:0]  log_ref;
  } cfg_regs_t;

  // Q16 log2(1 + i/n): Q1.30 start by shift-subtract division, then
  // twenty square-and-normalise steps give a Q20 value, rounded to Q16.
  function automatic logic [TAB_W-1:0] log_tab_entry(input int unsigned n,
                                                     input int unsigned i);
    longint unsigned num;
    longint unsigned rem;
    longint unsigned y;
    longint unsigned r;
    num = 64'(n + i) << 30;
    rem = 0;
    y   = 0;
    for (int b = 41; b >= 0; b--) begin
      rem = (rem << 1) | ((num >> b) & 64'd1);
      y   = y << 1;
      if (rem >= 64'(n)) begin
        rem = rem - 64'(n);
        y   = y | 64'd1;
      end
    end
    r = 0;
    for (int s = 0; s < 20; s++) begin
      y = (y * y) >> 30;
      r = r << 1;
      if (y >= 64'h8000_0000) begin
        r = r | 64'd1;
        y = y >> 1;
      end
    end
    return TAB_W'((r + 64'd8) >> 4);
  endfunction

endpackage

`default_nettype wire

### rtl/fnv_ifs.sv
// fnv_ifs: valid/ready channel interfaces for pitch estimates and results.
// Depends on fnv_pkg.
`default_nettype none

interface fnv_in_if;
  import fnv_pkg::*;
  logic                     valid;
  logic                     ready;
  logic [FREQ_W-1:0]        frequency;
  logic signed [MAG_W-1:0]  magnitude_db;

  modport source (output valid, output frequency, output magnitude_db, input ready);
  modport sink   (input valid, input frequency, input magnitude_db, output ready);
endinterface

interface fnv_out_if;
  import fnv_pkg::*;
  logic                      valid;
  logic                      ready;
  logic signed [NOTE_W-1:0]  note;
  logic signed [INTON_W-1:0] intonation;
  logic [VEL_W-1:0]          velocity;
  logic                      note_in_range;

  modport source (output valid, output note, output intonation, output velocity,
                  output note_in_range, input ready);
  modport sink   (input valid, input note, input intonation, input velocity,
                  input note_in_range, output ready);
endinterface

`default_nettype wire

### rtl/fnv_log_idx.sv
// fnv_log_idx: first half of log2 - leading-one detect, normalise and
// table index/weight split. Depends on fnv_pkg.
`default_nettype none

module fnv_log_idx #(
  parameter int unsigned LOG_TABLE_ENTRIES = fnv_pkg::LOG_TAB_ENTRIES_DEF
) (
  input  wire logic [fnv_pkg::FREQ_W-1:0]         x,
  output logic [fnv_pkg::EXP_W-1:0]               expo,
  output logic [$clog2(LOG_TABLE_ENTRIES)-1:0]    idx,
  output logic [fnv_pkg::FRAC_W-1:0]              wgt
);
  import fnv_pkg::*;

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned PW    = FRAC_W + IDX_W;

  logic [EXP_W-1:0]  shamt;
  logic [FREQ_W-1:0] mant;
  logic [PW-1:0]     prod;

  // leading one; zero input falls through to exponent 0, fraction 0
  always_comb begin
    expo = '0;
    for (int b = 1; b < FREQ_W; b++) begin
      if (x[b]) expo = EXP_W'(b);
    end
  end

  assign shamt = EXP_W'(FREQ_W - 1) - expo;
  assign mant  = x << shamt;
  assign prod  = PW'(mant[FRAC_W-1:0]) * PW'(LOG_TABLE_ENTRIES);
  assign idx   = prod[PW-1:FRAC_W];
  assign wgt   = prod[FRAC_W-1:0];

endmodule

`default_nettype wire

### rtl/fnv_log_interp.sv
// fnv_log_interp: second half of log2 - table lookup and linear
// interpolation into Q5.16. Depends on fnv_pkg.
`default_nettype none

module fnv_log_interp #(
  parameter int unsigned LOG_TABLE_ENTRIES = fnv_pkg::LOG_TAB_ENTRIES_DEF
) (
  input  wire logic [fnv_pkg::EXP_W-1:0]            expo,
  input  wire logic [$clog2(LOG_TABLE_ENTRIES)-1:0] idx,
  input  wire logic [fnv_pkg::FRAC_W-1:0]           wgt,
  output logic [fnv_pkg::LOG_W-1:0]                 log_q
);
  import fnv_pkg::*;

  localparam int unsigned TAB_AW = $clog2(LOG_TABLE_ENTRIES + 1);
  localparam int unsigned MUL_W  = TAB_W + FRAC_W;

  logic [TAB_W-1:0]  tab [LOG_TABLE_ENTRIES+1];
  logic [TAB_AW-1:0] idx_lo;
  logic [TAB_AW-1:0] idx_hi;
  logic [TAB_W-1:0]  lo;
  logic [TAB_W-1:0]  hi;
  logic [TAB_W-1:0]  diff;
  logic [MUL_W-1:0]  prod;

  for (genvar g = 0; g <= LOG_TABLE_ENTRIES; g++) begin : g_tab
    assign tab[g] = log_tab_entry(LOG_TABLE_ENTRIES, g);
  end

  assign idx_lo = TAB_AW'(idx);
  assign idx_hi = idx_lo + TAB_AW'(1);
  assign lo     = tab[idx_lo];
  assign hi     = tab[idx_hi];
  assign diff   = hi - lo;   // table rises monotonically
  assign prod   = MUL_W'(diff) * MUL_W'(wgt);
  assign log_q  = {expo, 16'b0} + LOG_W'(lo) + LOG_W'(prod >> FRAC_W);

endmodule

`default_nettype wire

### rtl/fnv_cfg.sv
// fnv_cfg: APB register file and the registered log2 of the reference pitch.
// Depends on fnv_pkg, fnv_log_idx, fnv_log_interp.
`default_nettype none

module fnv_cfg #(
  parameter int unsigned LOG_TABLE_ENTRIES = fnv_pkg::LOG_TAB_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [fnv_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [fnv_pkg::CFG_DW-1:0]  pwdata,
  output logic [fnv_pkg::CFG_DW-1:0]       prdata,
  output logic                             pready,
  output fnv_pkg::cfg_regs_t               cfg_q
);
  import fnv_pkg::*;

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_ENTRIES);

  logic [REG_IW-1:0] reg_idx;
  logic              wr_en;

  logic [FREQ_W-1:0] ref_freq_r;
  logic [NUM7_W-1:0] ref_note_r;
  logic [NUM7_W-1:0] low_note_r;
  logic [NUM7_W-1:0] high_note_r;
  logic [NUM7_W-1:0] vel_floor_r;
  logic [NUM7_W-1:0] vel_ceil_r;

  logic [EXP_W-1:0]  rexp_nxt;
  logic [IDX_W-1:0]  ridx_nxt;
  logic [FRAC_W-1:0] rwgt_nxt;
  logic [EXP_W-1:0]  rexp_r;
  logic [IDX_W-1:0]  ridx_r;
  logic [FRAC_W-1:0] rwgt_r;
  logic [LOG_W-1:0]  lref_nxt;
  logic [LOG_W-1:0]  lref_r;

  assign reg_idx = paddr[CFG_AW-1:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_freq_r  <= REF_FREQ_RST;
      ref_note_r  <= REF_NOTE_RST;
      low_note_r  <= LOW_NOTE_RST;
      high_note_r <= HIGH_NOTE_RST;
      vel_floor_r <= VEL_FLOOR_RST;
      vel_ceil_r  <= VEL_CEIL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_REF_FREQ:  ref_freq_r  <= pwdata[FREQ_W-1:0];
        REG_REF_NOTE:  ref_note_r  <= pwdata[NUM7_W-1:0];
        REG_LOW_NOTE:  low_note_r  <= pwdata[NUM7_W-1:0];
        REG_HIGH_NOTE: high_note_r <= pwdata[NUM7_W-1:0];
        REG_VEL_FLOOR: vel_floor_r <= pwdata[NUM7_W-1:0];
        REG_VEL_CEIL:  vel_ceil_r  <= pwdata[NUM7_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_REF_FREQ:  prdata = CFG_DW'(ref_freq_r);
      REG_REF_NOTE:  prdata = CFG_DW'(ref_note_r);
      REG_LOW_NOTE:  prdata = CFG_DW'(low_note_r);
      REG_HIGH_NOTE: prdata = CFG_DW'(high_note_r);
      REG_VEL_FLOOR: prdata = CFG_DW'(vel_floor_r);
      REG_VEL_CEIL:  prdata = CFG_DW'(vel_ceil_r);
      default:       prdata = '0;
    endcase
  end

  // log2 of the reference, two register stages; zero reads as log2(1) = 0
  fnv_log_idx #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_ref_idx (
    .x    (ref_freq_r),
    .expo (rexp_nxt),
    .idx  (ridx_nxt),
    .wgt  (rwgt_nxt)
  );

  always_ff @(posedge clk) begin
    rexp_r <= rexp_nxt;
    ridx_r <= ridx_nxt;
    rwgt_r <= rwgt_nxt;
    lref_r <= lref_nxt;
  end

  fnv_log_interp #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_ref_interp (
    .expo  (rexp_r),
    .idx   (ridx_r),
    .wgt   (rwgt_r),
    .log_q (lref_nxt)
  );

  always_comb begin
    cfg_q.ref_note     = ref_note_r;
    cfg_q.lowest_note  = low_note_r;
    cfg_q.highest_note = high_note_r;
    cfg_q.vel_floor    = vel_floor_r;
    cfg_q.vel_ceil     = vel_ceil_r;
    cfg_q.log_ref      = lref_r;
  end

endmodule

`default_nettype wire

### rtl/fnv_note.sv
// fnv_note: note rounding, intonation remainder, saturation and range flag.
// Depends on fnv_pkg.
`default_nettype none

module fnv_note (
  input  wire logic [fnv_pkg::LOG_W-1:0]    log_freq,
  input  wire logic                         is_zero,
  input  wire fnv_pkg::cfg_regs_t           cfg_q,
  output logic signed [fnv_pkg::NOTE_W-1:0]  note,
  output logic signed [fnv_pkg::INTON_W-1:0] intonation,
  output logic                               in_range
);
  import fnv_pkg::*;

  logic signed [LOG_W:0]  ldiff;
  logic signed [25:0]     dx;
  logic signed [25:0]     d12;
  logic signed [26:0]     n_q16;
  logic                   neg;
  logic [25:0]            n_abs;
  logic [26:0]            n_rnd;
  logic [10:0]            mag_note;
  logic signed [16:0]     r0;
  logic signed [16:0]     rem;
  logic [16:0]            rem_abs;
  logic [16:0]            q_abs;
  logic signed [11:0]     note_full;
  logic signed [NOTE_W-1:0] note_sat;
  logic signed [NOTE_W:0] note_x;

  always_comb begin
    // exact note in Q16: ref_note + 12 * (log2 f - log2 ref)
    ldiff = $signed({1'b0, log_freq}) - $signed({1'b0, cfg_q.log_ref});
    dx    = 26'(ldiff);
    d12   = (dx <<< 3) + (dx <<< 2);
    n_q16 = 27'(d12) + $signed({4'b0, cfg_q.ref_note, 16'b0});

    // round half away from zero on the magnitude
    neg      = n_q16[26];
    n_abs    = neg ? 26'(-n_q16) : 26'(n_q16);
    n_rnd    = 27'(n_abs) + 27'd32768;
    mag_note = n_rnd[26:16];
    r0       = $signed({1'b0, n_rnd[15:0]}) - 17'sd32768;
    rem      = neg ? -r0 : r0;
    note_full = neg ? -$signed({1'b0, mag_note}) : $signed({1'b0, mag_note});

    // remainder to 1/256 semitone, half away from zero
    rem_abs = rem[16] ? 17'(-rem) : 17'(rem);
    q_abs   = (rem_abs + 17'd128) >> 8;

    if (note_full > 12'(NOTE_MAX)) begin
      note_sat = NOTE_MAX;
    end else if (note_full < 12'(NOTE_MIN)) begin
      note_sat = NOTE_MIN;
    end else begin
      note_sat = NOTE_W'(note_full);
    end
    note_x = (NOTE_W+1)'(note_sat);

    if (is_zero) begin
      note       = NOTE_MIN;
      intonation = '0;
      in_range   = 1'b0;
    end else begin
      note       = note_sat;
      intonation = rem[16] ? -$signed(INTON_W'(q_abs)) : $signed(INTON_W'(q_abs));
      in_range   = (note_x >= $signed({3'b0, cfg_q.lowest_note})) &&
                   (note_x <= $signed({3'b0, cfg_q.highest_note}));
    end
  end

endmodule

`default_nettype wire

### rtl/freq_to_note_velocity.sv
// freq_to_note_velocity: top level - four-rank pipeline turning a pitch
// estimate into note, intonation, velocity and range flag.
// Depends on fnv_pkg, fnv_ifs, fnv_cfg, fnv_log_idx, fnv_log_interp, fnv_note.
//
//   port      dir  handshake            word
//   in_chan   in   valid/ready          frequency (Q16.8 Hz), magnitude_db (Q8.8 dB)
//   out_chan  out  valid/ready          note, intonation, velocity, note_in_range
//   cfg_*     in   APB, pready always 1 six registers at byte address 4*index
//
// One word per clock while out_chan.ready stays high; out_chan.valid rises once the
// word has moved from the input rank through the index, log and result ranks.
// The depth is set by the two multipliers of the log2 path: fraction times
// table size, then table slope times weight, each followed by a register.
// rst_n is synchronous: it empties the pipeline and loads the register defaults;
// after reset or a write the reference log settles through the index and log registers.
// Stalls: each rank fills whenever it is empty, so input words are still taken
// while a result sits unclaimed, until all four ranks hold a word.
`default_nettype none

module freq_to_note_velocity #(
  parameter int unsigned LOG_TABLE_ENTRIES = fnv_pkg::LOG_TAB_ENTRIES_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  fnv_in_if.sink                           in_chan,
  fnv_out_if.source                        out_chan,
  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [fnv_pkg::CFG_AW-1:0]  cfg_paddr,
  input  wire logic [fnv_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [fnv_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import fnv_pkg::*;

  localparam int unsigned IDX_W = $clog2(LOG_TABLE_ENTRIES);

  cfg_regs_t cfg_q;

  // rank enables: a rank loads when empty or when its successor moves on
  logic en0, en1, en2, en3;

  // rank 0: input word
  logic                    v0_r;
  logic [FREQ_W-1:0]       freq0_r;
  logic signed [MAG_W-1:0] mag0_r;

  // rank 1: log index/weight, zero flag, velocity numerator
  logic                    v1_r;
  logic [EXP_W-1:0]        exp1_nxt;
  logic [IDX_W-1:0]        idx1_nxt;
  logic [FRAC_W-1:0]       wgt1_nxt;
  logic [VEL_NUM_W-1:0]    vnum1_nxt;
  logic [EXP_W-1:0]        exp1_r;
  logic [IDX_W-1:0]        idx1_r;
  logic [FRAC_W-1:0]       wgt1_r;
  logic                    zero1_r;
  logic [VEL_NUM_W-1:0]    vnum1_r;

  // rank 2: log2 of the frequency, velocity
  logic                    v2_r;
  logic [LOG_W-1:0]        logf2_nxt;
  logic [VEL_W-1:0]        vel2_nxt;
  logic [LOG_W-1:0]        logf2_r;
  logic                    zero2_r;
  logic [VEL_W-1:0]        vel2_r;

  // rank 3: result
  logic                      v3_r;
  logic signed [NOTE_W-1:0]  note_nxt;
  logic signed [INTON_W-1:0] inton_nxt;
  logic                      range_nxt;
  logic signed [NOTE_W-1:0]  note_r;
  logic signed [INTON_W-1:0] inton_r;
  logic [VEL_W-1:0]          vel_r;
  logic                      range_r;

  // velocity helpers
  logic signed [MAG_W-1:0] mag_c;
  logic [VEL_K_W-1:0]      vel_k;
  logic [31:0]             vel_prod;

  fnv_cfg #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg_q   (cfg_q)
  );

  assign en3 = !v3_r || out_chan.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign en0 = !v0_r || en1;
  assign in_chan.ready = en0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en0) v0_r <= in_chan.valid;
      if (en1) v1_r <= v0_r;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  // ---- rank 0 -> 1: normalise, table split, velocity numerator ----
  fnv_log_idx #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_freq_idx (
    .x    (freq0_r),
    .expo (exp1_nxt),
    .idx  (idx1_nxt),
    .wgt  (wgt1_nxt)
  );

  // clamp to -100 .. -0.25 dB, k counts down from the loud end
  always_comb begin
    if (mag0_r < MAG_MIN_Q8) begin
      mag_c = MAG_MIN_Q8;
    end else if (mag0_r > MAG_MAX_Q8) begin
      mag_c = MAG_MAX_Q8;
    end else begin
      mag_c = mag0_r;
    end
    vel_k     = VEL_K_W'(MAG_MAX_Q8 - mag_c);
    vnum1_nxt = VEL_NUM_W'(cfg_q.vel_ceil) * VEL_NUM_W'(VEL_SPAN - vel_k) +
                VEL_NUM_W'(cfg_q.vel_floor) * VEL_NUM_W'(vel_k);
  end

  // ---- rank 1 -> 2: interpolate log, divide numerator by 25536 ----
  fnv_log_interp #(.LOG_TABLE_ENTRIES(LOG_TABLE_ENTRIES)) u_freq_interp (
    .expo  (exp1_r),
    .idx   (idx1_r),
    .wgt   (wgt1_r),
    .log_q (logf2_nxt)
  );

  // /64 by shift, /399 by reciprocal; exact over the numerator's range
  assign vel_prod = 32'(vnum1_r[VEL_NUM_W-1:VEL_PRE_SH]) * VEL_RECIP;
  assign vel2_nxt = VEL_W'(vel_prod >> VEL_RECIP_SH);

  // ---- rank 2 -> 3: note, intonation, range ----
  fnv_note u_note (
    .log_freq   (logf2_r),
    .is_zero    (zero2_r),
    .cfg_q      (cfg_q),
    .note       (note_nxt),
    .intonation (inton_nxt),
    .in_range   (range_nxt)
  );

  // payload ranks, no reset
  always_ff @(posedge clk) begin
    if (en0) begin
      freq0_r <= in_chan.frequency;
      mag0_r  <= in_chan.magnitude_db;
    end
    if (en1) begin
      exp1_r  <= exp1_nxt;
      idx1_r  <= idx1_nxt;
      wgt1_r  <= wgt1_nxt;
      zero1_r <= (freq0_r == '0);
      vnum1_r <= vnum1_nxt;
    end
    if (en2) begin
      logf2_r <= logf2_nxt;
      zero2_r <= zero1_r;
      vel2_r  <= vel2_nxt;
    end
    if (en3) begin
      note_r  <= note_nxt;
      inton_r <= inton_nxt;
      vel_r   <= vel2_r;
      range_r <= range_nxt;
    end
  end

  assign out_chan.valid         = v3_r;
  assign out_chan.note          = note_r;
  assign out_chan.intonation    = inton_r;
  assign out_chan.velocity      = vel_r;
  assign out_chan.note_in_range = range_r;

  // ---- checks ----
  // input only held off when every rank is full and the sink is stalled
  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_chan.ready |-> (v0_r && v1_r && v2_r && out_chan.valid && !out_chan.ready))
    else $error("input held off with a free rank");

  // zero frequency leaves the result rank as minimum note, out of range
  a_zero_freq: assert property (@(posedge clk) disable iff (!rst_n)
    (v2_r && en3 && zero2_r) |=>
      (out_chan.note == NOTE_MIN && !out_chan.note_in_range && out_chan.intonation == '0))
    else $error("zero frequency result wrong");

  // range flag agrees with the configured bounds
  a_range_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.note_in_range) |->
      ($signed(out_chan.note) >= $signed({2'b00, cfg_q.lowest_note}) &&
       $signed(out_chan.note) <= $signed({2'b00, cfg_q.highest_note})))
    else $error("note flagged in range outside bounds");

  // intonation stays within half a semitone
  a_inton_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> (out_chan.intonation >= -9'sd128 && out_chan.intonation <= 9'sd128))
    else $error("intonation outside half a semitone");

  // a stalled result is not overwritten by the rank behind it
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && !out_chan.ready) |=> (out_chan.valid && $stable(note_r) &&
                                              $stable(vel_r)))
    else $error("result lost under stall");

endmodule

`default_nettype wire
